/* rtl/mbr_pkg.sv */
// mbr_pkg: shared constants, types and counter helpers for the message byte ring FIFO.
// Used by mbr_adm and message_byte_ring_fifo. No dependencies.
package mbr_pkg;

	localparam int DEPTH     = 64;
	localparam int AW        = $clog2(DEPTH);
	localparam int CW        = $clog2(2 * DEPTH);
	localparam int CNT_MOD   = 2 * DEPTH;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 16;
	localparam int COUNT_W   = 7;
	localparam int DROP_W    = 32;

	localparam logic REQ_PUSH  = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef logic [CW-1:0] cnt_t;
	typedef logic [AW-1:0] slot_t;

	typedef struct packed {
		cnt_t wr_cnt;
		cnt_t rd_cnt;
	} ring_ptrs_t;

	typedef struct packed {
		logic              en;
		slot_t             addr;
		logic [BYTE_W-1:0] data;
	} ram_wr_t;

	// bytes between two counters, modulo twice the depth
	function automatic cnt_t cnt_used(input cnt_t e, input cnt_t s);
		logic [CW:0] d;
		d = {1'b0, e} - {1'b0, s};
		if (d[CW]) begin
			d = d + (CW+1)'(CNT_MOD);
		end
		return d[CW-1:0];
	endfunction

	function automatic cnt_t cnt_step(input cnt_t c);
		return (c == CW'(CNT_MOD - 1)) ? '0 : c + 1'b1;
	endfunction

	function automatic slot_t cnt_slot(input cnt_t c);
		cnt_t r;
		r = (c >= CW'(DEPTH)) ? c - CW'(DEPTH) : c;
		return r[AW-1:0];
	endfunction

endpackage

/* rtl/message_byte_ring_fifo.sv */
// message_byte_ring_fifo: top level - drain sequencer, output register, ring RAM
// and admission unit. Depends on mbr_pkg, mbr_ram, mbr_adm.
//
//  channel | handshake                 | beat
//  --------+---------------------------+---------------------------------------------
//  in      | in_valid / in_stall       | req_type, data_byte, msg_length, first/last
//  out     | out_valid / out_stall     | out_byte, byte_valid, last_of_drain,
//          |                           | drained_count, dropped_total
//
// A drain of N stored bytes gives N beats from the RAM read port, one per cycle
// while out_stall is low; an empty drain gives one beat. The input stalls while a
// drain is reading and while a result beat is held by out_stall.
// Reset clears counters and control; the RAM needs no clearing.
module message_byte_ring_fifo import mbr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic [LEN_W-1:0]   msg_length,
	input  logic               first_of_message,
	input  logic               last_of_message,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [BYTE_W-1:0]  out_byte,
	output logic               byte_valid,
	output logic               last_of_drain,
	output logic [COUNT_W-1:0] drained_count,
	output logic [DROP_W-1:0]  dropped_total
);

	typedef enum logic {ST_IDLE, ST_DRAIN} state_t;

	state_t             state_q;
	cnt_t               rd_ptr_q, remain_q;
	logic               ovalid_q, bvalid_q, last_q;
	logic [COUNT_W-1:0] count_q;
	logic [DROP_W-1:0]  drop_out_q;

	ring_ptrs_t         ptrs;
	ram_wr_t            wr;
	logic [DROP_W-1:0]  dropped;
	logic [BYTE_W-1:0]  rdata;

	logic               adv, acc, push_en, drain_en, re;
	slot_t              raddr;
	cnt_t               used, drain_cnt;

	always_comb begin
		adv       = !ovalid_q || !out_stall;
		in_stall  = (state_q != ST_IDLE) || !adv;
		acc       = in_valid && !in_stall;
		push_en   = acc && (req_type == REQ_PUSH);
		drain_en  = acc && (req_type == REQ_DRAIN);
		used      = cnt_used(ptrs.wr_cnt, ptrs.rd_cnt);
		drain_cnt = (used > CW'(DEPTH)) ? CW'(DEPTH) : used;
		re        = 1'b0;
		raddr     = cnt_slot(rd_ptr_q);
		if (state_q == ST_DRAIN && adv) begin
			re = 1'b1;
		end else if (drain_en && drain_cnt != '0) begin
			re    = 1'b1;
			raddr = cnt_slot(ptrs.rd_cnt);
		end
	end

	mbr_adm u_adm (
		.clk              (clk),
		.arst_n           (arst_n),
		.push_en          (push_en),
		.drain_en         (drain_en),
		.data_byte        (data_byte),
		.msg_length       (msg_length),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.ptrs             (ptrs),
		.wr               (wr),
		.dropped          (dropped)
	);

	mbr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_ptr_q   <= '0;
			remain_q   <= '0;
			ovalid_q   <= 1'b0;
			bvalid_q   <= 1'b0;
			last_q     <= 1'b0;
			count_q    <= '0;
			drop_out_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (drain_en) begin
						ovalid_q   <= 1'b1;
						count_q    <= COUNT_W'(drain_cnt);
						drop_out_q <= dropped;
						if (drain_cnt == '0) begin
							bvalid_q <= 1'b0;
							last_q   <= 1'b1;
						end else begin
							bvalid_q <= 1'b1;
							last_q   <= (drain_cnt == CW'(1));
							rd_ptr_q <= cnt_step(ptrs.rd_cnt);
							remain_q <= drain_cnt - 1'b1;
							if (drain_cnt != CW'(1)) begin
								state_q <= ST_DRAIN;
							end
						end
					end else if (adv) begin
						ovalid_q <= 1'b0;
					end
				end
				ST_DRAIN: begin
					if (adv) begin
						ovalid_q <= 1'b1;
						bvalid_q <= 1'b1;
						last_q   <= (remain_q == CW'(1));
						rd_ptr_q <= cnt_step(rd_ptr_q);
						remain_q <= remain_q - 1'b1;
						if (remain_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = ovalid_q;
	assign out_byte      = bvalid_q ? rdata : '0;
	assign byte_valid    = bvalid_q;
	assign last_of_drain = last_q;
	assign drained_count = count_q;
	assign dropped_total = drop_out_q;

`ifndef NO_ASSERTIONS
	a_idle_nothing_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> remain_q == '0)
		else $error("bytes left to read while sequencer idle");

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_used(ptrs.wr_cnt, ptrs.rd_cnt) <= CW'(DEPTH))
		else $error("ring occupancy beyond depth");

	a_drain_continues: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && bvalid_q && !last_q && !out_stall |=> ovalid_q && bvalid_q)
		else $error("drain stopped before its last beat");

	a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> !push_en && !drain_en && !wr.en)
		else $error("input taken during drain");
`endif

endmodule

/* rtl/mbr_ram.sv */
// mbr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/mbr_adm.sv */
// mbr_adm: message admission unit - free-space check, pending pointer, commit,
// ring counters and dropped-byte total. Depends on mbr_pkg.
module mbr_adm import mbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_en,
	input  logic              drain_en,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [LEN_W-1:0]  msg_length,
	input  logic              first_of_message,
	input  logic              last_of_message,
	output ring_ptrs_t        ptrs,
	output ram_wr_t           wr,
	output logic [DROP_W-1:0] dropped
);

	cnt_t              wr_cnt_q, rd_cnt_q, pend_q;
	logic              adm_q;
	logic [DROP_W-1:0] dropped_q;

	logic              fits;
	cnt_t              pend_eff, pend_new;
	logic              adm_eff;
	logic              store;
	logic [LEN_W:0]    need;

	always_comb begin
		need     = {1'b0, msg_length} + (LEN_W+1)'(cnt_used(wr_cnt_q, rd_cnt_q));
		fits     = need <= (LEN_W+1)'(DEPTH);
		pend_eff = first_of_message ? wr_cnt_q : pend_q;
		adm_eff  = first_of_message ? fits : adm_q;
		store    = adm_eff && (cnt_used(pend_eff, rd_cnt_q) < CW'(DEPTH));
		pend_new = store ? cnt_step(pend_eff) : pend_eff;
		wr.en    = push_en && store;
		wr.addr  = cnt_slot(pend_eff);
		wr.data  = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q  <= '0;
			rd_cnt_q  <= '0;
			pend_q    <= '0;
			adm_q     <= 1'b0;
			dropped_q <= '0;
		end else begin
			if (push_en) begin
				pend_q <= pend_new;
				if (first_of_message && !fits) begin
					dropped_q <= dropped_q + DROP_W'(msg_length);
				end
				if (adm_eff && last_of_message) begin
					wr_cnt_q <= pend_new;
					adm_q    <= 1'b0;
				end else begin
					adm_q <= adm_eff;
				end
			end
			if (drain_en) begin
				rd_cnt_q <= wr_cnt_q;
			end
		end
	end

	assign ptrs.wr_cnt = wr_cnt_q;
	assign ptrs.rd_cnt = rd_cnt_q;
	assign dropped     = dropped_q;

endmodule

/* bench/message_byte_ring_fifo_tb.sv */
`timescale 1ns / 1ps
// message_byte_ring_fifo_tb: self-checking bench for the message byte ring FIFO.
// Predicts each drained beat from the accepted requests; needs mbr_pkg and the RTL.
module message_byte_ring_fifo_tb;
	import mbr_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic               valid;
		logic               last;
		logic [COUNT_W-1:0] count;
		logic [DROP_W-1:0]  dropped;
	} drain_beat_t;

	class drain_scoreboard;
		logic [BYTE_W-1:0] ring [DEPTH];
		cnt_t              wr_cnt;
		cnt_t              rd_cnt;
		cnt_t              open_cnt;
		bit                msg_open;
		logic [DROP_W-1:0] dropped_sum;
		drain_beat_t       due [$];
		int                errors;

		function new();
			foreach (ring[k]) ring[k] = '0;
			wr_cnt = '0;
			rd_cnt = '0;
			open_cnt = '0;
			msg_open = 1'b0;
			dropped_sum = '0;
			errors = 0;
		endfunction

		// returns 0 for a push byte that is not a first byte and finds no admitted message open
		function bit note_request(input logic rq, input logic [BYTE_W-1:0] d,
				input logic [LEN_W-1:0] len, input logic f, input logic l);
			cnt_t        n;
			int          room;
			int          i;
			drain_beat_t b;
			if (rq == REQ_DRAIN) begin
				n = wr_cnt - rd_cnt;
				if (n == 0) begin
					b = '{data: '0, valid: 1'b0, last: 1'b1, count: '0, dropped: dropped_sum};
					due.push_back(b);
				end else begin
					for (i = 0; i < int'(n); i++) begin
						b.data = ring[slot_t'(rd_cnt + cnt_t'(i))];
						b.valid = 1'b1;
						b.last = (i == int'(n) - 1);
						b.count = COUNT_W'(n);
						b.dropped = dropped_sum;
						due.push_back(b);
					end
					rd_cnt = wr_cnt;
				end
				return 1'b1;
			end
			if (f) begin
				room = DEPTH - int'(cnt_t'(wr_cnt - rd_cnt));
				open_cnt = wr_cnt;
				if (int'(len) > room) begin
					dropped_sum = dropped_sum + DROP_W'(len);
					msg_open = 1'b0;
				end else begin
					msg_open = 1'b1;
				end
			end
			if (!msg_open) return f;
			if (int'(cnt_t'(open_cnt - rd_cnt)) < DEPTH) begin
				ring[slot_t'(open_cnt)] = d;
				open_cnt = open_cnt + 1'b1;
			end
			if (l) begin
				wr_cnt = open_cnt;
				msg_open = 1'b0;
			end
			return 1'b1;
		endfunction

		task report(input string what);
			errors++;
			if (errors <= 40) $display("%0t mismatch: %s", $time, what);
		endtask

		task check_beat(input drain_beat_t got);
			drain_beat_t exp;
			if (due.size() == 0) begin
				report($sformatf("beat with nothing due, out_byte %h", got.data));
				return;
			end
			exp = due.pop_front();
			if (got.data !== exp.data)
				report($sformatf("out_byte %h, due %h", got.data, exp.data));
			if (got.valid !== exp.valid)
				report($sformatf("byte_valid %b, due %b", got.valid, exp.valid));
			if (got.last !== exp.last)
				report($sformatf("last_of_drain %b, due %b", got.last, exp.last));
			if (got.count !== exp.count)
				report($sformatf("drained_count %0d, due %0d", got.count, exp.count));
			if (got.dropped !== exp.dropped)
				report($sformatf("dropped_total %0d, due %0d", got.dropped, exp.dropped));
		endtask
	endclass

	localparam int IDLE_LIMIT = 4000;
	localparam int ITEM_TARGET = 450;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               req_type = REQ_PUSH;
	logic [BYTE_W-1:0]  data_byte = '0;
	logic [LEN_W-1:0]   msg_length = '0;
	logic               first_of_message = 1'b0;
	logic               last_of_message = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [BYTE_W-1:0]  out_byte;
	logic               byte_valid;
	logic               last_of_drain;
	logic [COUNT_W-1:0] drained_count;
	logic [DROP_W-1:0]  dropped_total;

	drain_scoreboard sb;
	int  live_items = 0;
	bit  steady = 1'b0;
	int  hold_left = 0;
	int  free_left = 0;
	int  idle_cycles = 0;

	message_byte_ring_fifo dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.data_byte        (data_byte),
		.msg_length       (msg_length),
		.first_of_message (first_of_message),
		.last_of_message  (last_of_message),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_byte         (out_byte),
		.byte_valid       (byte_valid),
		.last_of_drain    (last_of_drain),
		.drained_count    (drained_count),
		.dropped_total    (dropped_total)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// drives the request and returns once the DUT has taken it (in_stall low)
	task automatic send_req(input logic rq, input logic [BYTE_W-1:0] d,
			input logic [LEN_W-1:0] len, input logic f, input logic l);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		data_byte <= d;
		msg_length <= len;
		first_of_message <= f;
		last_of_message <= l;
		do @(posedge clk); while (in_stall);
		void'(sb.note_request(rq, d, len, f, l));
		live_items++;
	endtask

	task automatic directed();
		send_req(REQ_DRAIN, 8'h00, 16'h0000, 1'b0, 1'b0);
		send_req(REQ_PUSH, 8'hAA, 16'hFFFF, 1'b1, 1'b0);
		// stray byte, nothing open
		send_req(REQ_PUSH, 8'h55, 16'h0000, 1'b0, 1'b1);
		send_req(REQ_DRAIN, 8'hFF, 16'hFFFF, 1'b1, 1'b1);
		send_req(REQ_PUSH, 8'h77, 16'd65, 1'b1, 1'b1);
		send_req(REQ_PUSH, 8'hFF, 16'd1, 1'b1, 1'b1);
		send_req(REQ_PUSH, 8'h00, 16'd0, 1'b1, 1'b0);
		send_req(REQ_PUSH, 8'h5A, 16'h1234, 1'b0, 1'b0);
		send_req(REQ_PUSH, 8'hA5, 16'hEDCB, 1'b0, 1'b1);
		send_req(REQ_PUSH, 8'h11, 16'd3, 1'b1, 1'b0);
		// open message must survive this drain
		send_req(REQ_DRAIN, 8'h00, 16'd0, 1'b0, 1'b0);
		send_req(REQ_PUSH, 8'h22, 16'd0, 1'b0, 1'b0);
		// restart abandons the open bytes
		send_req(REQ_PUSH, 8'h33, 16'd2, 1'b1, 1'b0);
		send_req(REQ_PUSH, 8'h44, 16'd0, 1'b0, 1'b1);
		send_req(REQ_DRAIN, 8'h00, 16'd0, 1'b0, 1'b0);
		send_req(REQ_DRAIN, 8'h00, 16'd0, 1'b0, 1'b0);
	endtask

	task automatic random_message();
		int pick;
		int len;
		int nbytes;
		int cut_at;
		int i;
		bit no_last;
		if ($urandom_range(0, 15) == 0) steady = !steady;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			send_req(REQ_DRAIN, BYTE_W'($urandom), LEN_W'($urandom), 1'($urandom),
				1'($urandom));
			return;
		end
		if (pick < 20) begin
			send_req(REQ_PUSH, BYTE_W'($urandom), LEN_W'($urandom), 1'($urandom),
				1'($urandom));
			return;
		end
		pick = $urandom_range(0, 99);
		if (pick < 55) len = $urandom_range(0, 24);
		else if (pick < 80) len = $urandom_range(25, DEPTH);
		else if (pick < 90) len = $urandom_range(DEPTH + 1, DEPTH + 16);
		else len = $urandom_range(0, 65535);
		nbytes = (len > DEPTH + 16) ? $urandom_range(1, 4) : len;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			nbytes += ($urandom_range(0, 3) == 0) ? $urandom_range(7, 70) : $urandom_range(1, 6);
		else if (pick < 25 && nbytes > 1)
			nbytes = $urandom_range(1, nbytes - 1);
		if (nbytes == 0) nbytes = 1;
		no_last = ($urandom_range(0, 11) == 0);
		cut_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nbytes - 1) : -1;
		for (i = 0; i < nbytes; i++) begin
			if (i == cut_at)
				send_req(REQ_DRAIN, BYTE_W'($urandom), LEN_W'($urandom), 1'($urandom),
					1'($urandom));
			send_req(REQ_PUSH, BYTE_W'($urandom), (i == 0) ? LEN_W'(len) : LEN_W'($urandom),
				i == 0, (i == nbytes - 1) && !no_last);
		end
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (free_left > 0) begin
				free_left--;
			end else begin
				hold_left = pick_gap();
				free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
					: $urandom_range(0, 6);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_beat('{out_byte, byte_valid, last_of_drain, drained_count, dropped_total});
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("message_byte_ring_fifo_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed();
		while (live_items < ITEM_TARGET) random_message();
		in_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("message_byte_ring_fifo_tb: clean");
		end else begin
			$display("message_byte_ring_fifo_tb: errors");
		end
		$finish;
	end

endmodule
